>>> rtl/page_allocator_refcount_assert.svh
// Assertion macros for the page allocator, empty in synthesis.
`ifndef PAGE_ALLOCATOR_REFCOUNT_ASSERT_SVH
`define PAGE_ALLOCATOR_REFCOUNT_ASSERT_SVH
`ifndef SYNTHESIS
`define PAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page allocator: implication check failed");
`define PAL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page allocator: next-cycle check failed");
`else
`define PAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PAL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/pal_pkg.sv
// Shared types, codes and defaults of the page allocator.
package pal_pkg;

  localparam int NUM_PAGES_DEF  = 32768;
  localparam int COUNT_BITS_DEF = 8;

  localparam int KIND_W     = 2;
  localparam int PAGE_IO_W  = 15;
  localparam int COUNT_IO_W = 8;
  localparam int STATUS_W   = 3;
  localparam int FREE_IO_W  = 16;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PAGE_IO_W-1:0] page;
  } pal_req_t;

  typedef struct packed {
    logic [FREE_IO_W-1:0]  pool_free;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_IO_W-1:0] count;
    logic [PAGE_IO_W-1:0]  page;
  } pal_result_t;

endpackage

>>> rtl/pal_ram.sv
// Simple dual-port synchronous RAM, one write port, one registered read port.
module pal_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32768,
  parameter int ADDR_W = 15
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pal_engine.sv
// Allocator core: free stack and count memories, read-modify-write per request.
`include "page_allocator_refcount_assert.svh"
module pal_engine #(
  parameter int NUM_PAGES  = pal_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = pal_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [pal_pkg::PAGE_IO_W-1:0]    first_usable_page,
  input  logic                             start,
  input  pal_pkg::pal_req_t                req,
  input  logic                             out_free,
  output logic                             busy,
  output logic                             done,
  output pal_pkg::pal_result_t             res
);
  import pal_pkg::*;

  localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int NUM_W  = $clog2(NUM_PAGES + 1);
  localparam int XW     = (NUM_W > FREE_IO_W) ? NUM_W : FREE_IO_W;
  localparam int EXT_CW = (COUNT_BITS > COUNT_IO_W) ? COUNT_BITS : COUNT_IO_W;
  localparam logic [XW-1:0]         NUM_X     = XW'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  logic [KIND_W-1:0]    op_kind;
  logic [PAGE_IO_W-1:0] op_page;
  logic [XW-1:0]        stack_depth, stack_depth_next;
  logic [XW-1:0]        fresh_limit, fresh_limit_next;

  logic                  cnt_we;
  logic [PAGE_W-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  stk_we;
  logic [PAGE_W-1:0]     stk_rdata;

  logic [XW-1:0]        req_page_x, page_x, fu_x, depth_dec, fresh_dec;
  logic [XW-1:0]        alloc_x, fresh_left, free_next;
  logic [PAGE_W-1:0]    alloc_page;
  logic                 alloc_from_stack, in_range;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_dec, cnt_inc, res_cnt;
  logic [EXT_CW-1:0]    res_cnt_x;
  logic [PAGE_IO_W-1:0] res_page;
  logic [STATUS_W-1:0]  res_status;

  assign done = busy && out_free;

  assign req_page_x = XW'(req.page);
  assign page_x     = XW'(op_page);
  assign fu_x       = XW'(first_usable_page);
  assign depth_dec  = stack_depth - XW'(1);
  assign fresh_dec  = fresh_limit - XW'(1);

  // counts of pages never handed out live below the fresh pointer and read as zero
  assign cnt_cur  = (page_x >= fresh_limit) ? cnt_rdata : '0;
  assign cnt_dec  = cnt_cur - COUNT_ONE;
  assign cnt_inc  = cnt_cur + COUNT_ONE;
  assign in_range = (page_x >= fu_x) && (page_x < NUM_X);

  assign alloc_from_stack = (stack_depth != '0);
  assign alloc_page       = alloc_from_stack ? stk_rdata : fresh_dec[PAGE_W-1:0];
  assign alloc_x          = XW'(alloc_page);

  pal_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES),
    .ADDR_W(PAGE_W)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we && done),
    .waddr(cnt_waddr),
    .wdata(cnt_wdata),
    .re   (start),
    .raddr(req_page_x[PAGE_W-1:0]),
    .rdata(cnt_rdata)
  );

  pal_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES),
    .ADDR_W(PAGE_W)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we && done),
    .waddr(stack_depth[PAGE_W-1:0]),
    .wdata(page_x[PAGE_W-1:0]),
    .re   (start),
    .raddr(depth_dec[PAGE_W-1:0]),
    .rdata(stk_rdata)
  );

  always_comb begin
    stack_depth_next = stack_depth;
    fresh_limit_next = fresh_limit;
    cnt_we           = 1'b0;
    cnt_waddr        = page_x[PAGE_W-1:0];
    cnt_wdata        = cnt_dec;
    stk_we           = 1'b0;
    res_page         = op_page;
    res_cnt          = '0;
    res_status       = ST_OK;
    case (op_kind)
      KIND_ALLOC: begin
        if (alloc_from_stack || (fresh_limit > fu_x)) begin
          if (alloc_from_stack) begin
            stack_depth_next = depth_dec;
          end else begin
            fresh_limit_next = fresh_dec;
          end
          cnt_we    = 1'b1;
          cnt_waddr = alloc_page;
          cnt_wdata = COUNT_ONE;
          res_page  = alloc_x[PAGE_IO_W-1:0];
          res_cnt   = COUNT_ONE;
        end else begin
          res_page   = '0;
          res_status = ST_EMPTY;
        end
      end
      KIND_RELEASE, KIND_ADD: begin
        if (!in_range) begin
          res_status = ST_RANGE;
        end else if (cnt_cur == '0) begin
          res_status = ST_NOTALLOC;
        end else if (op_kind == KIND_RELEASE) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_dec;
          res_cnt   = cnt_dec;
          if (cnt_dec == '0) begin
            stk_we           = 1'b1;
            stack_depth_next = stack_depth + XW'(1);
          end
        end else if (cnt_cur == COUNT_MAX) begin
          res_cnt    = cnt_cur;
          res_status = ST_OVERFLOW;
        end else begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_inc;
          res_cnt   = cnt_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign fresh_left = (fresh_limit_next > fu_x) ? (fresh_limit_next - fu_x) : '0;
  assign free_next  = stack_depth_next + fresh_left;
  assign res_cnt_x  = EXT_CW'(res_cnt);

  assign res.page      = res_page;
  assign res.count     = res_cnt_x[COUNT_IO_W-1:0];
  assign res.status    = res_status;
  assign res.pool_free = free_next[FREE_IO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      stack_depth <= '0;
      fresh_limit <= NUM_X;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy        <= 1'b0;
        stack_depth <= stack_depth_next;
        fresh_limit <= fresh_limit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_kind <= req.kind;
      op_page <= req.page;
    end
  end

  // stack holds only pages already taken from the fresh range
  `PAL_ASSERT_IMP(a_stack_bound, clk, rst, 1'b1, ({1'b0, stack_depth} + {1'b0, fresh_limit}) <= {1'b0, NUM_X})
  `PAL_ASSERT_NXT(a_fresh_down, clk, rst, 1'b1, fresh_limit <= $past(fresh_limit))
  `PAL_ASSERT_NXT(a_start_busy, clk, rst, start, busy)
  `PAL_ASSERT_IMP(a_no_start_busy, clk, rst, busy, !start)

endmodule

>>> rtl/page_allocator_refcount.sv
// The result beat follows its accepted request through the busy state and the output
// register, held back only while the previous result beat waits for m_axis_tready.
// One request at a time: s_axis_tready stays low over the count-memory read-modify-write
// (read in the accept cycle, write-back as the result enters the output register).
// Reset: synchronous; no clearing pass, counts below the fresh pointer read
// as zero, so requests are taken from the first cycle after reset.
module page_allocator_refcount #(
  parameter int NUM_PAGES  = pal_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = pal_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,      // first_usable_page
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // kind[1:0], page_index[16:2], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // result_page[14:0], ref_count[22:15],
                                      // status[25:23], pool_free[41:26], pad
);
  import pal_pkg::*;

  logic [PAGE_IO_W-1:0] first_usable_page;
  logic                 start, busy, done, out_free;
  pal_req_t             req;
  pal_result_t          res;
  pal_result_t          out_beat;

  assign req.kind  = s_axis_tdata[KIND_W-1:0];
  assign req.page  = s_axis_tdata[KIND_W +: PAGE_IO_W];
  assign s_axis_tready = !busy;
  assign start     = s_axis_tvalid && !busy;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  pal_engine #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .first_usable_page(first_usable_page),
    .start            (start),
    .req              (req),
    .out_free         (out_free),
    .busy             (busy),
    .done             (done),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable_page <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        first_usable_page <= cfg_wdata;
      end
      if (done) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_beat <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_beat.pool_free, out_beat.status,
                         out_beat.count, out_beat.page};

endmodule

>>> verif/page_allocator_refcount_tb.sv
// Self-checking testbench for the page allocator: directed table, then random request phases.
module page_allocator_refcount_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_pkg::*;

  localparam int PAGE_COUNT = NUM_PAGES_DEF;
  localparam int HOLD_LEN   = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DIR_ROWS   = 26;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // kind[1:0], page_index[16:2], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // result_page[14:0], ref_count[22:15],
                                    // status[25:23], pool_free[41:26], pad

  page_allocator_refcount dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // allocator mirror
  logic [14:0] freed_stack [PAGE_COUNT];
  logic [7:0]  page_refs [PAGE_COUNT];
  int          stack_top;
  int          fresh_ptr;
  int          floor_page;
  int          live_pages [$];

  pal_result_t pending_results [$];
  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_reqs = 0;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  kind;
    logic [14:0] page;   // register value on a config row
    bit          typed;
    logic [14:0] want_page;
    logic [7:0]  want_count;
    logic [2:0]  want_status;
    logic [15:0] want_free;
  } plan_row_t;

  plan_row_t plan [DIR_ROWS] = '{
    '{0, KIND_ALLOC,   15'd0,     1, 15'd32767, 8'd1, ST_OK,       16'd32767},
    '{0, KIND_ALLOC,   15'd0,     1, 15'd32766, 8'd1, ST_OK,       16'd32766},
    '{0, KIND_ADD,     15'd32767, 1, 15'd32767, 8'd2, ST_OK,       16'd32766},
    '{0, KIND_RELEASE, 15'd32767, 1, 15'd32767, 8'd1, ST_OK,       16'd32766},
    '{0, KIND_RELEASE, 15'd32767, 1, 15'd32767, 8'd0, ST_OK,       16'd32767},
    '{0, KIND_RELEASE, 15'd32767, 1, 15'd32767, 8'd0, ST_NOTALLOC, 16'd32767},
    '{0, KIND_ADD,     15'd32767, 1, 15'd32767, 8'd0, ST_NOTALLOC, 16'd32767},
    '{0, KIND_ALLOC,   15'd12345, 1, 15'd32767, 8'd1, ST_OK,       16'd32766},
    '{0, KIND_ADD,     15'd0,     1, 15'd0,     8'd0, ST_NOTALLOC, 16'd32766},
    '{0, KIND_NOP,     15'd32767, 1, 15'd32767, 8'd0, ST_OK,       16'd32766},
    '{0, KIND_NOP,     15'd0,     1, 15'd0,     8'd0, ST_OK,       16'd32766},
    '{0, KIND_RELEASE, 15'd16384, 1, 15'd16384, 8'd0, ST_NOTALLOC, 16'd32766},
    '{0, KIND_RELEASE, 15'd32766, 1, 15'd32766, 8'd0, ST_OK,       16'd32767},
    '{0, KIND_RELEASE, 15'd32767, 1, 15'd32767, 8'd0, ST_OK,       16'd32768},
    '{1, KIND_NOP,     15'd32767, 0, 15'd0,     8'd0, ST_OK,       16'd0},
    '{0, KIND_ALLOC,   15'd0,     1, 15'd32767, 8'd1, ST_OK,       16'd1},
    '{0, KIND_RELEASE, 15'd32766, 1, 15'd32766, 8'd0, ST_RANGE,    16'd1},
    '{0, KIND_ALLOC,   15'd0,     1, 15'd32766, 8'd1, ST_OK,       16'd0},
    '{0, KIND_ALLOC,   15'd0,     1, 15'd0,     8'd0, ST_EMPTY,    16'd0},
    '{0, KIND_ADD,     15'd0,     1, 15'd0,     8'd0, ST_RANGE,    16'd0},
    '{0, KIND_RELEASE, 15'd32767, 1, 15'd32767, 8'd0, ST_OK,       16'd1},
    '{1, KIND_NOP,     15'd0,     0, 15'd0,     8'd0, ST_OK,       16'd0},
    '{0, KIND_ALLOC,   15'd0,     1, 15'd32767, 8'd1, ST_OK,       16'd32766},
    '{0, KIND_ADD,     15'd32767, 0, 15'd0,     8'd0, ST_OK,       16'd0},
    '{0, KIND_RELEASE, 15'd32766, 0, 15'd0,     8'd0, ST_OK,       16'd0},
    '{0, KIND_NOP,     15'd21845, 0, 15'd0,     8'd0, ST_OK,       16'd0}
  };

  function automatic pal_result_t apply_request(logic [1:0] kind, logic [14:0] page);
    pal_result_t r;
    int          p;
    r.page   = page;
    r.count  = '0;
    r.status = ST_OK;
    case (kind)
      KIND_ALLOC: begin
        r.page = '0;
        p = -1;
        if (stack_top > 0) begin
          stack_top--;
          p = freed_stack[stack_top];
        end else if (fresh_ptr > floor_page) begin
          fresh_ptr--;
          p = fresh_ptr;
        end
        if (p < 0) begin
          r.status = ST_EMPTY;
        end else begin
          page_refs[p] = 8'd1;
          r.page  = p[14:0];
          r.count = 8'd1;
          live_pages.push_back(p);
        end
      end
      KIND_NOP: ;
      default: begin
        if (page < floor_page) begin
          r.status = ST_RANGE;
        end else if (page_refs[page] == '0) begin
          r.status = ST_NOTALLOC;
        end else if (kind == KIND_RELEASE) begin
          page_refs[page]--;
          r.count = page_refs[page];
          if (page_refs[page] == '0) begin
            freed_stack[stack_top] = page;
            stack_top++;
            for (int i = 0; i < live_pages.size(); i++)
              if (live_pages[i] == page) begin
                live_pages.delete(i);
                break;
              end
          end
        end else if (page_refs[page] == '1) begin
          r.status = ST_OVERFLOW;
          r.count  = page_refs[page];
        end else begin
          page_refs[page]++;
          r.count = page_refs[page];
        end
      end
    endcase
    r.pool_free = 16'(stack_top + ((fresh_ptr > floor_page) ? fresh_ptr - floor_page : 0));
    return r;
  endfunction

  // drive one request beat and hold it until the block takes it
  task automatic offer_beat(logic [1:0] kind, logic [14:0] page);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, page, kind};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_request(logic [1:0] kind, logic [14:0] page, output pal_result_t r);
    offer_beat(kind, page);
    r = apply_request(kind, page);
    pending_results.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_floor(logic [14:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    floor_page = value;
  endtask

  task automatic random_request();
    pal_result_t r;
    logic [1:0]  kind;
    logic [14:0] page;
    int          sel;
    sel  = $urandom_range(99);
    kind = 2'($urandom_range(3));
    page = 15'($urandom_range(32767));
    if (sel < 30) begin
      kind = KIND_ALLOC;
    end else if (sel < 62 && live_pages.size() != 0) begin
      kind = KIND_RELEASE;
      page = 15'(live_pages[$urandom_range(live_pages.size() - 1)]);
    end else if (sel < 77 && live_pages.size() != 0) begin
      kind = KIND_ADD;
      page = 15'(live_pages[$urandom_range(live_pages.size() - 1)]);
    end else if (sel < 85 && stack_top > 0) begin
      // touch a page that is already back on the free stack
      kind = sel[0] ? KIND_RELEASE : KIND_ADD;
      page = freed_stack[stack_top - 1];
    end else if (sel < 92) begin
      page = 15'(floor_page + $urandom_range(2) - 1);
    end
    send_request(kind, page, r);
  endtask

  task automatic run_phase(logic [14:0] floor_val, int tx_pct, int rx_pct, int n);
    write_floor(floor_val);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (n) random_request();
  endtask

  // push one page to the count limit and back down to free
  task automatic saturate_one_page();
    pal_result_t r;
    logic [14:0] pg;
    send_request(KIND_ALLOC, 15'($urandom_range(32767)), r);
    if (r.status == ST_OK) begin
      pg = r.page;
      repeat (256) send_request(KIND_ADD, pg, r);
      repeat (256) send_request(KIND_RELEASE, pg, r);
    end
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: backpressure, with an occasional long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    pal_result_t got;
    pal_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = pal_result_t'(m_axis_tdata[41:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_page", want.page, got.page);
        compare_field("ref_count", want.count, got.count);
        compare_field("status", want.status, got.status);
        compare_field("pool_free", want.pool_free, got.pool_free);
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    pal_result_t r;
    for (int i = 0; i < PAGE_COUNT; i++) page_refs[i] = '0;
    stack_top  = 0;
    fresh_ptr  = PAGE_COUNT;
    floor_page = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_floor(plan[i].page);
      end else begin
        offer_beat(plan[i].kind, plan[i].page);
        r = apply_request(plan[i].kind, plan[i].page);
        if (plan[i].typed) begin
          r.page      = plan[i].want_page;
          r.count     = plan[i].want_count;
          r.status    = plan[i].want_status;
          r.pool_free = plan[i].want_free;
        end
        pending_results.push_back(r);
      end
    end

    // small pool: empties and refills from released pages
    run_phase(15'd32760, 0, 0, 250);
    run_phase(15'($urandom_range(1, 32766)), 61, 0, 300);
    run_phase(15'd32767, 0, 61, 200);
    run_phase(15'd0, 34, 34, 150);
    saturate_one_page();
    repeat (150) random_request();

    // long receiver hold-off while requests keep coming
    write_floor(15'($urandom_range(32767)));
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    repeat (180) random_request();
    wait_drained();
    repeat (180) random_request();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
